FILE: src/mmb_pkg.sv
package mmb_pkg;

    // Field widths of the channels.
    localparam int TIME_W   = 32;
    localparam int KIND_W   = 2;
    localparam int CHAN_W   = 5;
    localparam int DATA_W   = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;

    // Register widths.
    localparam int BPM_W   = 9;
    localparam int BAR_W   = 5;
    localparam int COUNT_W = 4;
    localparam int SENT_W  = 8;

    // Message kinds.
    localparam logic [KIND_W-1:0] KIND_PROGRAM  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CONTROL  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSTRUMENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCENT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BPM        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BAR        = 3'd7;

    // Reset values of the registers.
    localparam logic [CHAN_W-1:0] RST_CHANNEL = 5'd1;
    localparam logic [DATA_W-1:0] RST_ACCENT  = 7'd76;
    localparam logic [DATA_W-1:0] RST_PLAIN   = 7'd77;
    localparam logic [DATA_W-1:0] RST_VOLUME  = 7'd100;
    localparam logic [BPM_W-1:0]  RST_BPM     = 9'd120;
    localparam logic [BAR_W-1:0]  RST_BAR     = 5'd4;
    localparam logic [SENT_W-1:0] SENT_NONE   = 8'd255;

    // Fixed message data.
    localparam logic [DATA_W-1:0] VOLUME_CONTROLLER = 7'd7;
    localparam logic [DATA_W-1:0] FULL_VELOCITY     = 7'd127;
    localparam logic [TIME_W-1:0] RESTART_OFFSET    = 32'd200;

    // Serial divider.
    localparam int DIV_W  = 16;
    localparam int REM_W  = BPM_W;
    localparam logic [DIV_W-1:0] PERIOD_DIVIDEND = 16'd60000;

    // floor(x / 10) for 16-bit x is (x * 0xCCCD) >> 19.
    localparam logic [DIV_W-1:0] TENTH_MUL   = 16'hCCCD;
    localparam int               TENTH_SHIFT = 19;
    localparam int               TENTH_W     = 13;

    // floor(128 * p / 100) for p below 100 is (p * 5243) >> 12.
    localparam logic [12:0] VOL_MUL   = 13'd5243;
    localparam int          VOL_SHIFT = 12;
    localparam int          VOL_PROD_W = 20;
    localparam logic [DATA_W-1:0] VOL_CLAMP_PCT = 7'd100;
    localparam logic [DATA_W-1:0] VOL_MAX       = 7'd127;

    // Pending message slots, emitted lowest first.
    localparam int NUM_SLOTS = 5;
    localparam int SLOT_W    = 3;
    localparam logic [SLOT_W-1:0] SLOT_PROGRAM  = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_OFF_ACC  = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_OFF_PLN  = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_CONTROL  = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_NOTE_ON  = 3'd4;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_DIV_P = 6'b000100,
        S_STOP  = 6'b001000,
        S_DIV_M = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

endpackage

FILE: src/mmb_if.sv
interface mmb_in_if;
    logic                        valid;
    logic                        ready;
    logic [mmb_pkg::TIME_W-1:0]  now_ms;
    logic [mmb_pkg::TIME_W-1:0]  loop_start_ms;

    modport source (output valid, output now_ms, output loop_start_ms, input ready);
    modport sink   (input valid, input now_ms, input loop_start_ms, output ready);
endinterface

interface mmb_out_if;
    logic                        valid;
    logic                        ready;
    logic [mmb_pkg::KIND_W-1:0]  msg_kind;
    logic [mmb_pkg::CHAN_W-1:0]  channel;
    logic [mmb_pkg::DATA_W-1:0]  data_first;
    logic [mmb_pkg::DATA_W-1:0]  data_second;
    logic                        last;

    modport source (output valid, output msg_kind, output channel, output data_first,
                    output data_second, output last, input ready);
    modport sink   (input valid, input msg_kind, input channel, input data_first,
                    input data_second, input last, output ready);
endinterface

interface mmb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mmb_pkg::CFG_IDX_W-1:0]  index;
    logic [mmb_pkg::CFG_DAT_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/midi_metronome_beat_generator.sv
// Flow: a request while disabled only re-arms the deadlines and is absorbed in idle. An enabled
// request passes through evaluation and then message emission; a beat request also runs the
// period division, the deadline update and, unless the bar length is zero, the counter modulus
// division in between. A receiver stall holds the block in emission. A new request is taken
// only once the previous one is done. One serial divider serves both divisions.
// Reset: i_rst_n is synchronous, active low; control registers reset, payload registers do not.
module midi_metronome_beat_generator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mmb_cfg_if.sink   i_cfg,
    mmb_in_if.sink    i_in,
    mmb_out_if.source o_out
);

    // Configuration registers.
    logic                            r_cfg_en;
    logic [mmb_pkg::DATA_W-1:0]      r_cfg_instr;
    logic [mmb_pkg::CHAN_W-1:0]      r_cfg_chan;
    logic [mmb_pkg::DATA_W-1:0]      r_cfg_accent;
    logic [mmb_pkg::DATA_W-1:0]      r_cfg_plain;
    logic [mmb_pkg::DATA_W-1:0]      r_cfg_vol;
    logic [mmb_pkg::BPM_W-1:0]       r_cfg_bpm;
    logic [mmb_pkg::BAR_W-1:0]       r_cfg_bar;

    // Metronome state.
    mmb_pkg::t_state                 r_state, n_state;
    logic [mmb_pkg::COUNT_W-1:0]     r_count, n_count;
    logic [mmb_pkg::TIME_W-1:0]      r_beat_dl, n_beat_dl;
    logic [mmb_pkg::TIME_W-1:0]      r_stop_dl, n_stop_dl;
    logic                            r_sounding, n_sounding;
    logic [mmb_pkg::SENT_W-1:0]      r_sent, n_sent;

    // Per-request working registers.
    logic [mmb_pkg::TIME_W-1:0]      r_now, n_now;
    logic [mmb_pkg::NUM_SLOTS-1:0]   r_pend, n_pend;
    logic [mmb_pkg::DATA_W-1:0]      r_note, n_note;
    logic [mmb_pkg::DATA_W-1:0]      r_vol, n_vol;

    // Shared restoring divider.
    logic [mmb_pkg::DIV_W-1:0]       r_dv_acc, n_dv_acc;
    logic [mmb_pkg::REM_W-1:0]       r_dv_rem, n_dv_rem;
    logic [3:0]                      r_dv_cnt, n_dv_cnt;

    // Output register.
    logic                            r_out_vld, n_out_vld;
    logic [mmb_pkg::KIND_W-1:0]      r_out_kind, n_out_kind;
    logic [mmb_pkg::DATA_W-1:0]      r_out_first, n_out_first;
    logic [mmb_pkg::DATA_W-1:0]      r_out_second, n_out_second;
    logic                            r_out_last, n_out_last;

    logic                            w_in_acc;
    logic [mmb_pkg::BPM_W-1:0]       w_bpm_eff;
    logic [mmb_pkg::BPM_W-1:0]       w_dv_div;
    logic [mmb_pkg::REM_W:0]         w_dv_trial;
    logic                            w_dv_ge;
    logic [mmb_pkg::REM_W-1:0]       w_dv_rem_nx;
    logic [mmb_pkg::DIV_W-1:0]       w_dv_acc_nx;
    logic [2*mmb_pkg::DIV_W-1:0]     w_tenth_prod;
    logic [mmb_pkg::TENTH_W-1:0]     w_tenth;
    logic [mmb_pkg::VOL_PROD_W-1:0]  w_vol_prod;
    logic [mmb_pkg::DATA_W-1:0]      w_vol;
    logic                            w_pc_hit;
    logic                            w_off_hit;
    logic                            w_beat_hit;
    logic [mmb_pkg::SLOT_W-1:0]      w_sel;
    logic                            w_out_free;
    logic [mmb_pkg::KIND_W-1:0]      w_msg_kind;
    logic [mmb_pkg::DATA_W-1:0]      w_msg_first;
    logic [mmb_pkg::DATA_W-1:0]      w_msg_second;
    logic [mmb_pkg::NUM_SLOTS-1:0]   w_sel_mask;

    // Registers may be written at any cycle; the port never stalls.
    assign i_cfg.ready = 1'b1;

    // A new request is taken only when the sequencer is idle. The output register may still be
    // holding the final message of the previous request at that point.
    assign i_in.ready = (r_state == mmb_pkg::S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_vld;
    assign o_out.msg_kind    = r_out_kind;
    assign o_out.channel     = r_cfg_chan;
    assign o_out.data_first  = r_out_first;
    assign o_out.data_second = r_out_second;
    assign o_out.last        = r_out_last;

    // A tempo of zero is treated as one beat per minute.
    assign w_bpm_eff = (r_cfg_bpm == '0) ? mmb_pkg::BPM_W'(1) : r_cfg_bpm;

    // One restoring-division step per cycle: shift the next dividend bit into the partial
    // remainder, subtract the divisor when it fits, and shift the quotient bit in behind.
    // The same unit computes the beat period and the beat counter modulus.
    assign w_dv_div    = (r_state == mmb_pkg::S_DIV_M) ?
                         mmb_pkg::BPM_W'(r_cfg_bar) : w_bpm_eff;
    assign w_dv_trial  = {r_dv_rem, r_dv_acc[mmb_pkg::DIV_W-1]};
    assign w_dv_ge     = (w_dv_trial >= {1'b0, w_dv_div});
    assign w_dv_rem_nx = w_dv_ge ? mmb_pkg::REM_W'(w_dv_trial - {1'b0, w_dv_div}) :
                                   mmb_pkg::REM_W'(w_dv_trial);
    assign w_dv_acc_nx = {r_dv_acc[mmb_pkg::DIV_W-2:0], w_dv_ge};

    // The note length is one tenth of the beat period, since floor(floor(a/b)/10) equals
    // floor(a/(10b)). The tenth is taken by a reciprocal multiply.
    assign w_tenth_prod = {{mmb_pkg::DIV_W{1'b0}}, r_dv_acc} *
                          {{mmb_pkg::DIV_W{1'b0}}, mmb_pkg::TENTH_MUL};
    assign w_tenth      = w_tenth_prod[mmb_pkg::TENTH_SHIFT +: mmb_pkg::TENTH_W];

    // Volume is floor(128 * percent / 100). Anything from 100 percent up saturates at 127;
    // below that the reciprocal multiply is exact.
    assign w_vol_prod = mmb_pkg::VOL_PROD_W'(r_cfg_vol) * mmb_pkg::VOL_PROD_W'(mmb_pkg::VOL_MUL);
    assign w_vol      = (r_cfg_vol >= mmb_pkg::VOL_CLAMP_PCT) ? mmb_pkg::VOL_MAX :
                        w_vol_prod[mmb_pkg::VOL_SHIFT +: mmb_pkg::DATA_W];

    // Decisions of an enabled request, evaluated against the captured time.
    assign w_pc_hit   = ({1'b0, r_cfg_instr} != r_sent);
    assign w_off_hit  = (r_now >= r_stop_dl) && r_sounding;
    assign w_beat_hit = (r_now >= r_beat_dl);

    // The lowest pending slot is the next message; it is the final one when no other slot
    // is pending behind it.
    always_comb begin
        w_sel = mmb_pkg::SLOT_NOTE_ON;
        for (int k = mmb_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_sel = mmb_pkg::SLOT_W'(k);
            end
        end
    end

    assign w_sel_mask = mmb_pkg::NUM_SLOTS'(1) << w_sel;

    always_comb begin
        unique case (w_sel)
            mmb_pkg::SLOT_PROGRAM: begin
                w_msg_kind   = mmb_pkg::KIND_PROGRAM;
                w_msg_first  = r_cfg_instr;
                w_msg_second = '0;
            end
            mmb_pkg::SLOT_OFF_ACC: begin
                w_msg_kind   = mmb_pkg::KIND_NOTE_OFF;
                w_msg_first  = r_cfg_accent;
                w_msg_second = '0;
            end
            mmb_pkg::SLOT_OFF_PLN: begin
                w_msg_kind   = mmb_pkg::KIND_NOTE_OFF;
                w_msg_first  = r_cfg_plain;
                w_msg_second = '0;
            end
            mmb_pkg::SLOT_CONTROL: begin
                w_msg_kind   = mmb_pkg::KIND_CONTROL;
                w_msg_first  = mmb_pkg::VOLUME_CONTROLLER;
                w_msg_second = r_vol;
            end
            default: begin
                w_msg_kind   = mmb_pkg::KIND_NOTE_ON;
                w_msg_first  = r_note;
                w_msg_second = mmb_pkg::FULL_VELOCITY;
            end
        endcase
    end

    // The output register can take a message when it is empty or being drained this cycle.
    assign w_out_free = !r_out_vld || o_out.ready;

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_beat_dl    = r_beat_dl;
        n_stop_dl    = r_stop_dl;
        n_sounding   = r_sounding;
        n_sent       = r_sent;
        n_now        = r_now;
        n_pend       = r_pend;
        n_note       = r_note;
        n_vol        = r_vol;
        n_dv_acc     = r_dv_acc;
        n_dv_rem     = r_dv_rem;
        n_dv_cnt     = r_dv_cnt;
        n_out_vld    = r_out_vld && !o_out.ready;
        n_out_kind   = r_out_kind;
        n_out_first  = r_out_first;
        n_out_second = r_out_second;
        n_out_last   = r_out_last;

        unique case (r_state)
            mmb_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_now = i_in.now_ms;
                    if (!r_cfg_en) begin
                        // Disabled: re-arm from the loop start and emit nothing.
                        n_count    = mmb_pkg::COUNT_W'(1);
                        n_beat_dl  = i_in.loop_start_ms + mmb_pkg::RESTART_OFFSET;
                        n_stop_dl  = i_in.loop_start_ms + mmb_pkg::RESTART_OFFSET;
                        n_sounding = 1'b0;
                    end else begin
                        n_state = mmb_pkg::S_EVAL;
                    end
                end
            end
            mmb_pkg::S_EVAL: begin
                n_pend = {w_beat_hit, w_beat_hit, w_off_hit, w_off_hit, w_pc_hit};
                if (w_pc_hit) begin
                    n_sent = {1'b0, r_cfg_instr};
                end
                if (w_off_hit) begin
                    n_sounding = 1'b0;
                end
                // The note is chosen from the counter before it advances.
                n_note = (r_count == mmb_pkg::COUNT_W'(1)) ? r_cfg_accent : r_cfg_plain;
                n_vol  = w_vol;
                if (w_beat_hit) begin
                    n_sounding = 1'b1;
                    n_dv_acc   = mmb_pkg::PERIOD_DIVIDEND;
                    n_dv_rem   = '0;
                    n_dv_cnt   = '0;
                    n_state    = mmb_pkg::S_DIV_P;
                end else begin
                    n_state = mmb_pkg::S_EMIT;
                end
            end
            mmb_pkg::S_DIV_P: begin
                n_dv_acc = w_dv_acc_nx;
                n_dv_rem = w_dv_rem_nx;
                n_dv_cnt = r_dv_cnt + 4'd1;
                if (r_dv_cnt == 4'd15) begin
                    n_state = mmb_pkg::S_STOP;
                end
            end
            mmb_pkg::S_STOP: begin
                // The quotient register holds the beat period now.
                n_beat_dl = r_now + mmb_pkg::TIME_W'(r_dv_acc);
                n_stop_dl = r_now + mmb_pkg::TIME_W'(w_tenth);
                if (r_cfg_bar == '0) begin
                    // A zero bar length parks the counter at zero.
                    n_count = '0;
                    n_state = mmb_pkg::S_EMIT;
                end else begin
                    n_dv_acc = mmb_pkg::DIV_W'(r_count) + mmb_pkg::DIV_W'(1);
                    n_dv_rem = '0;
                    n_dv_cnt = '0;
                    n_state  = mmb_pkg::S_DIV_M;
                end
            end
            mmb_pkg::S_DIV_M: begin
                n_dv_acc = w_dv_acc_nx;
                n_dv_rem = w_dv_rem_nx;
                n_dv_cnt = r_dv_cnt + 4'd1;
                if (r_dv_cnt == 4'd15) begin
                    // The remainder is the advanced counter, kept to four bits.
                    n_count = w_dv_rem_nx[mmb_pkg::COUNT_W-1:0];
                    n_state = mmb_pkg::S_EMIT;
                end
            end
            mmb_pkg::S_EMIT: begin
                if (r_pend == '0) begin
                    n_state = mmb_pkg::S_IDLE;
                end else if (w_out_free) begin
                    n_out_vld    = 1'b1;
                    n_out_kind   = w_msg_kind;
                    n_out_first  = w_msg_first;
                    n_out_second = w_msg_second;
                    n_out_last   = ((r_pend & ~w_sel_mask) == '0);
                    n_pend       = r_pend & ~w_sel_mask;
                end
            end
            default: begin
                n_state = mmb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mmb_pkg::S_IDLE;
            r_count    <= mmb_pkg::COUNT_W'(1);
            r_beat_dl  <= '0;
            r_stop_dl  <= '0;
            r_sounding <= 1'b0;
            r_sent     <= mmb_pkg::SENT_NONE;
            r_pend     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_beat_dl  <= n_beat_dl;
            r_stop_dl  <= n_stop_dl;
            r_sounding <= n_sounding;
            r_sent     <= n_sent;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload and working registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_now        <= n_now;
        r_note       <= n_note;
        r_vol        <= n_vol;
        r_dv_acc     <= n_dv_acc;
        r_dv_rem     <= n_dv_rem;
        r_dv_cnt     <= n_dv_cnt;
        r_out_kind   <= n_out_kind;
        r_out_first  <= n_out_first;
        r_out_second <= n_out_second;
        r_out_last   <= n_out_last;
    end

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_en     <= 1'b0;
            r_cfg_instr  <= '0;
            r_cfg_chan   <= mmb_pkg::RST_CHANNEL;
            r_cfg_accent <= mmb_pkg::RST_ACCENT;
            r_cfg_plain  <= mmb_pkg::RST_PLAIN;
            r_cfg_vol    <= mmb_pkg::RST_VOLUME;
            r_cfg_bpm    <= mmb_pkg::RST_BPM;
            r_cfg_bar    <= mmb_pkg::RST_BAR;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                mmb_pkg::CFG_ENABLED:    r_cfg_en     <= i_cfg.data[0];
                mmb_pkg::CFG_INSTRUMENT: r_cfg_instr  <= i_cfg.data[mmb_pkg::DATA_W-1:0];
                mmb_pkg::CFG_CHANNEL:    r_cfg_chan   <= i_cfg.data[mmb_pkg::CHAN_W-1:0];
                mmb_pkg::CFG_ACCENT:     r_cfg_accent <= i_cfg.data[mmb_pkg::DATA_W-1:0];
                mmb_pkg::CFG_PLAIN:      r_cfg_plain  <= i_cfg.data[mmb_pkg::DATA_W-1:0];
                mmb_pkg::CFG_VOLUME:     r_cfg_vol    <= i_cfg.data[mmb_pkg::DATA_W-1:0];
                mmb_pkg::CFG_BPM:        r_cfg_bpm    <= i_cfg.data[mmb_pkg::BPM_W-1:0];
                mmb_pkg::CFG_BAR:        r_cfg_bar    <= i_cfg.data[mmb_pkg::BAR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer never returns to idle with messages still queued.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmb_pkg::S_IDLE) |-> (r_pend == '0))
        else $error("idle with pending messages");

    // The period division only runs after a beat has marked the note as sounding.
    a_div_sounding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmb_pkg::S_DIV_P) |-> r_sounding)
        else $error("beat division without sounding note");

    // Evaluation always follows an accepted request.
    a_eval_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mmb_pkg::S_EVAL) |-> $past(i_in.valid && i_in.ready))
        else $error("evaluation without a request");

endmodule

FILE: verif/tb_midi_metronome_beat_generator.sv
module tb_midi_metronome_beat_generator;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles allowed after the last expected message before the block counts as idle.
    localparam int SETTLE_CYCLES   = 64;
    // Cycles with no request moved on any channel before the run is declared hung.
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int RANDOM_PHASES   = 12;
    localparam int TICKS_PER_PHASE = 34;

    typedef struct packed {
        logic [mmb_pkg::KIND_W-1:0] kind;
        logic [mmb_pkg::CHAN_W-1:0] chan;
        logic [mmb_pkg::DATA_W-1:0] first;
        logic [mmb_pkg::DATA_W-1:0] second;
        logic                       last;
    } t_midi_msg;

    typedef struct packed {
        logic [mmb_pkg::TIME_W-1:0] now_ms;
        logic [mmb_pkg::TIME_W-1:0] loop_start_ms;
    } t_tick;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mmb_cfg_if cfg_if ();
    mmb_in_if  in_if ();
    mmb_out_if out_if ();

    midi_metronome_beat_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // The clock runs at 100 MHz.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Our own copy of the metronome registers, updated when a write is accepted.
    logic                       m_enabled    = 1'b0;
    logic [mmb_pkg::DATA_W-1:0] m_instrument = '0;
    logic [mmb_pkg::CHAN_W-1:0] m_channel    = mmb_pkg::RST_CHANNEL;
    logic [mmb_pkg::DATA_W-1:0] m_accent     = mmb_pkg::RST_ACCENT;
    logic [mmb_pkg::DATA_W-1:0] m_plain      = mmb_pkg::RST_PLAIN;
    logic [mmb_pkg::DATA_W-1:0] m_volume     = mmb_pkg::RST_VOLUME;
    logic [mmb_pkg::BPM_W-1:0]  m_bpm        = mmb_pkg::RST_BPM;
    logic [mmb_pkg::BAR_W-1:0]  m_bar        = mmb_pkg::RST_BAR;

    // Our own copy of the beat state.
    logic [mmb_pkg::COUNT_W-1:0] m_count    = 4'd1;
    logic [mmb_pkg::TIME_W-1:0]  m_beat_dl  = '0;
    logic [mmb_pkg::TIME_W-1:0]  m_stop_dl  = '0;
    logic                        m_sounding = 1'b0;
    logic [mmb_pkg::SENT_W-1:0]  m_sent     = mmb_pkg::SENT_NONE;

    // Ticks waiting for the driver, and MIDI messages the block still owes us.
    t_tick     tick_backlog[$];
    t_midi_msg owed_midi[$];

    int unsigned ticks_queued   = 0;
    int unsigned ticks_accepted = 0;
    int unsigned mismatches     = 0;
    int unsigned idle_cycles    = 0;
    logic        tick_taken     = 1'b0;
    t_midi_msg   want_msg;
    t_tick       next_tick;

    // Time cursor for well-formed tick streams; it wraps like the block's time does.
    logic [mmb_pkg::TIME_W-1:0] clock_ms   = '0;
    logic [mmb_pkg::TIME_W-1:0] restart_ms = '0;

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic t_midi_msg make_msg(input logic [mmb_pkg::KIND_W-1:0] kind,
                                           input logic [mmb_pkg::DATA_W-1:0] first,
                                           input logic [mmb_pkg::DATA_W-1:0] second);
        t_midi_msg msg;
        msg.kind   = kind;
        msg.chan   = m_channel;
        msg.first  = first;
        msg.second = second;
        msg.last   = 1'b0;
        return msg;
    endfunction

    // Works out the MIDI messages one tick causes and advances the beat state.
    function automatic void tick_to_midi(input logic [mmb_pkg::TIME_W-1:0] now,
                                         input logic [mmb_pkg::TIME_W-1:0] loop_start);
        t_midi_msg   burst[$];
        int unsigned volume;
        int unsigned tempo;
        int unsigned next_count;
        // While the metronome is off it only re-arms itself from the loop start.
        if (!m_enabled) begin
            m_count    = 4'd1;
            m_beat_dl  = loop_start + mmb_pkg::RESTART_OFFSET;
            m_stop_dl  = loop_start + mmb_pkg::RESTART_OFFSET;
            m_sounding = 1'b0;
            return;
        end
        // The program change goes out whenever the instrument differs from the last one sent.
        if ({1'b0, m_instrument} != m_sent) begin
            burst.push_back(make_msg(mmb_pkg::KIND_PROGRAM, m_instrument, '0));
            m_sent = {1'b0, m_instrument};
        end
        // Both notes are silenced once the stop deadline has passed.
        if (now >= m_stop_dl && m_sounding) begin
            burst.push_back(make_msg(mmb_pkg::KIND_NOTE_OFF, m_accent, '0));
            burst.push_back(make_msg(mmb_pkg::KIND_NOTE_OFF, m_plain, '0));
            m_sounding = 1'b0;
        end
        // A beat sends the volume, then the click, and re-arms both deadlines from now.
        if (now >= m_beat_dl) begin
            volume = (128 * m_volume) / 100;
            if (volume > 127) begin
                volume = 127;
            end
            tempo = (m_bpm == 0) ? 1 : m_bpm;
            burst.push_back(make_msg(mmb_pkg::KIND_CONTROL, mmb_pkg::VOLUME_CONTROLLER,
                                     mmb_pkg::DATA_W'(volume)));
            burst.push_back(make_msg(mmb_pkg::KIND_NOTE_ON,
                                     (m_count == 1) ? m_accent : m_plain,
                                     mmb_pkg::FULL_VELOCITY));
            m_beat_dl  = now + 60000 / tempo;
            m_stop_dl  = now + 6000 / tempo;
            next_count = (m_bar == 0) ? 0 : (m_count + 1) % m_bar;
            m_count    = mmb_pkg::COUNT_W'(next_count);
            m_sounding = 1'b1;
        end
        if (burst.size() != 0) begin
            burst[burst.size() - 1].last = 1'b1;
        end
        foreach (burst[i]) begin
            owed_midi.push_back(burst[i]);
        end
    endfunction

    // Monitor: samples all three channels at the rising edge. Accepted ticks feed the
    // prediction, accepted messages are checked against the oldest owed message, and
    // the watchdog counts cycles in which nothing moved anywhere.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_taken  = 1'b0;
            idle_cycles = 0;
        end else begin
            tick_taken = in_if.valid && in_if.ready;
            if (tick_taken) begin
                tick_to_midi(in_if.now_ms, in_if.loop_start_ms);
                ticks_accepted++;
            end
            if (out_if.valid && out_if.ready) begin
                if (owed_midi.size() == 0) begin
                    report_mismatch("message with none owed, kind", out_if.msg_kind, 0);
                end else begin
                    want_msg = owed_midi.pop_front();
                    if (out_if.msg_kind !== want_msg.kind) begin
                        report_mismatch("msg_kind", out_if.msg_kind, want_msg.kind);
                    end
                    if (out_if.channel !== want_msg.chan) begin
                        report_mismatch("channel", out_if.channel, want_msg.chan);
                    end
                    if (out_if.data_first !== want_msg.first) begin
                        report_mismatch("data_first", out_if.data_first, want_msg.first);
                    end
                    if (out_if.data_second !== want_msg.second) begin
                        report_mismatch("data_second", out_if.data_second, want_msg.second);
                    end
                    if (out_if.last !== want_msg.last) begin
                        report_mismatch("last", out_if.last, want_msg.last);
                    end
                end
            end
            if (tick_taken || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles == WATCHDOG_LIMIT) begin
                    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("tb_midi_metronome_beat_generator: errors");
                    $finish;
                end
            end
        end
    end

    // Tick driver: sends the backlog in bursts of random length with random gaps, and
    // holds a request steady until the block takes it.
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || tick_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (tick_backlog.size() != 0) begin
                next_tick = tick_backlog.pop_front();
                in_if.valid         <= 1'b1;
                in_if.now_ms        <= next_tick.now_ms;
                in_if.loop_start_ms <= next_tick.loop_start_ms;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // One burst in four runs straight into the next one.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                    burst_left = $urandom_range(0, 15);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Message receiver: ready follows a rotating 16-bit pattern that is swapped out for a new
    // random one when its age runs out. Patterns range from always ready to one cycle in sixteen.
    logic [15:0] ready_pattern = 16'hFFFF;
    int unsigned pattern_age   = 0;

    always @(negedge i_clk) begin
        if (pattern_age == 0) begin
            pattern_age = $urandom_range(24, 96);
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'($urandom);
                2: ready_pattern = 16'($urandom) | 16'($urandom);
                default: ready_pattern = 16'h0001;
            endcase
            if (ready_pattern == 16'h0000) begin
                ready_pattern = 16'h0001;
            end
        end
        pattern_age--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        out_if.ready <= ready_pattern[0];
    end

    // Writes one register and updates our copy at the edge where the write is taken.
    // The valid is left high so that back-to-back writes follow one another without a pause.
    task automatic set_reg(input logic [mmb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mmb_pkg::CFG_DAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) begin
            @(posedge i_clk);
        end
        case (idx)
            mmb_pkg::CFG_ENABLED:    m_enabled    = val[0];
            mmb_pkg::CFG_INSTRUMENT: m_instrument = val[mmb_pkg::DATA_W-1:0];
            mmb_pkg::CFG_CHANNEL:    m_channel    = val[mmb_pkg::CHAN_W-1:0];
            mmb_pkg::CFG_ACCENT:     m_accent     = val[mmb_pkg::DATA_W-1:0];
            mmb_pkg::CFG_PLAIN:      m_plain      = val[mmb_pkg::DATA_W-1:0];
            mmb_pkg::CFG_VOLUME:     m_volume     = val[mmb_pkg::DATA_W-1:0];
            mmb_pkg::CFG_BPM:        m_bpm        = val;
            default:                 m_bar        = val[mmb_pkg::BAR_W-1:0];
        endcase
    endtask

    // Ends a group of writes; returns on a rising edge so that new ticks are queued
    // away from the driver's edge.
    task automatic cfg_idle();
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every tick is taken and every owed message has come, then lets a
    // tick that causes no message finish inside the block.
    task automatic drain();
        while (ticks_accepted != ticks_queued || owed_midi.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_tick(input logic [mmb_pkg::TIME_W-1:0] now,
                              input logic [mmb_pkg::TIME_W-1:0] loop_start);
        tick_backlog.push_back(t_tick'{now_ms: now, loop_start_ms: loop_start});
        ticks_queued++;
    endtask

    // Picks a register value: mostly in range, often at an end of the range, and now
    // and then any 9-bit pattern so that the unused upper bits get exercised too.
    function automatic logic [mmb_pkg::CFG_DAT_W-1:0] pick_value(
        input logic [mmb_pkg::CFG_IDX_W-1:0] idx);
        int unsigned lo;
        int unsigned hi;
        case (idx)
            mmb_pkg::CFG_CHANNEL: begin lo = 1; hi = 16;  end
            mmb_pkg::CFG_VOLUME:  begin lo = 0; hi = 100; end
            mmb_pkg::CFG_BPM:     begin lo = 1; hi = 300; end
            mmb_pkg::CFG_BAR:     begin lo = 1; hi = 16;  end
            default:              begin lo = 0; hi = 127; end
        endcase
        case ($urandom_range(0, 9))
            0:       return mmb_pkg::CFG_DAT_W'(lo);
            1:       return mmb_pkg::CFG_DAT_W'(hi);
            2:       return mmb_pkg::CFG_DAT_W'($urandom);
            default: return mmb_pkg::CFG_DAT_W'($urandom_range(lo, hi));
        endcase
    endfunction

    // Queues a stream of ticks whose time mostly moves forward in steps sized to the
    // current tempo, so that note-offs and beats keep coming. A few ticks repeat the
    // time, step backward, or jump to an arbitrary time.
    task automatic queue_stream(input int count);
        int unsigned period;
        int unsigned note_len;
        int unsigned sel;
        period   = 60000 / ((m_bpm == 0) ? 1 : m_bpm);
        note_len = 6000 / ((m_bpm == 0) ? 1 : m_bpm);
        repeat (count) begin
            sel = $urandom_range(0, 15);
            if (sel < 3) begin
                clock_ms += $urandom_range(1, note_len + 1);
            end else if (sel < 12) begin
                clock_ms += $urandom_range(period / 2, period + note_len);
            end else if (sel < 13) begin
                clock_ms += $urandom_range(period, 4 * period);
            end else if (sel < 14) begin
                clock_ms -= $urandom_range(1, period);
            end else if (sel < 15) begin
                clock_ms = $urandom;
            end
            queue_tick(clock_ms, $urandom);
        end
    endtask

    initial begin
        cfg_if.valid        = 1'b0;
        cfg_if.index        = mmb_pkg::CFG_ENABLED;
        cfg_if.data         = '0;
        in_if.valid         = 1'b0;
        in_if.now_ms        = '0;
        in_if.loop_start_ms = '0;
        out_if.ready        = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // While disabled, ticks only re-arm the deadlines. The second loop start makes
        // loop start plus 200 wrap around to 199.
        queue_tick(32'd0, 32'd0);
        queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Default settings, enabled. The first tick sends only the program change, then
        // come an accent beat, the tick just before the note ends, the note-offs, a plain
        // beat at the top of the time range whose deadlines wrap, and a tick with
        // note-offs and a beat together.
        set_reg(mmb_pkg::CFG_ENABLED, 9'd1);
        cfg_idle();
        queue_tick(32'd0, 32'd0);
        queue_tick(32'd199, 32'd0);
        queue_tick(32'd248, 32'd0);
        queue_tick(32'd249, 32'd0);
        queue_tick(32'hFFFF_FFFF, 32'd0);
        queue_tick(32'd0, 32'hFFFF_FFFF);
        queue_tick(32'd500, 32'd0);
        drain();

        // Zero tempo counts as one beat per minute, zero beats per bar pins the counter
        // at zero so the plain note plays, volume above 100 percent clamps, and channel
        // zero passes through. The first tick carries all four message kinds, five messages in all.
        set_reg(mmb_pkg::CFG_INSTRUMENT, 9'd127);
        set_reg(mmb_pkg::CFG_CHANNEL, 9'd0);
        set_reg(mmb_pkg::CFG_ACCENT, 9'd127);
        set_reg(mmb_pkg::CFG_PLAIN, 9'd0);
        set_reg(mmb_pkg::CFG_VOLUME, 9'd127);
        set_reg(mmb_pkg::CFG_BPM, 9'd0);
        set_reg(mmb_pkg::CFG_BAR, 9'd0);
        cfg_idle();
        queue_tick(32'd1000, 32'd0);
        queue_tick(32'd7000, 32'd0);
        queue_tick(32'd61000, 32'd0);
        drain();

        // Tempo and beats per bar above their ranges, the widest channel value and zero
        // volume. The beats come back to back at the shortest beat period.
        set_reg(mmb_pkg::CFG_INSTRUMENT, 9'd0);
        set_reg(mmb_pkg::CFG_CHANNEL, 9'd31);
        set_reg(mmb_pkg::CFG_ACCENT, 9'd0);
        set_reg(mmb_pkg::CFG_PLAIN, 9'd127);
        set_reg(mmb_pkg::CFG_VOLUME, 9'd0);
        set_reg(mmb_pkg::CFG_BPM, 9'd511);
        set_reg(mmb_pkg::CFG_BAR, 9'd31);
        cfg_idle();
        for (int k = 0; k < 6; k++) begin
            queue_tick(32'd121000 + 32'(k * 117), $urandom);
        end
        drain();

        // Full volume, top of the tempo range, one beat per bar, highest legal channel.
        set_reg(mmb_pkg::CFG_VOLUME, 9'd100);
        set_reg(mmb_pkg::CFG_BPM, 9'd300);
        set_reg(mmb_pkg::CFG_BAR, 9'd1);
        set_reg(mmb_pkg::CFG_CHANNEL, 9'd16);
        cfg_idle();
        clock_ms = 32'd122000;
        queue_stream(4);

        // Random phases: each retunes a random subset of the registers, sometimes turns
        // the metronome off for a few ticks around a new loop start, then plays a stream.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain();
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_INSTRUMENT, pick_value(mmb_pkg::CFG_INSTRUMENT));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_CHANNEL, pick_value(mmb_pkg::CFG_CHANNEL));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_ACCENT, pick_value(mmb_pkg::CFG_ACCENT));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_PLAIN, pick_value(mmb_pkg::CFG_PLAIN));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_VOLUME, pick_value(mmb_pkg::CFG_VOLUME));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_BPM, pick_value(mmb_pkg::CFG_BPM));
            end
            if ($urandom_range(0, 1) != 0) begin
                set_reg(mmb_pkg::CFG_BAR, pick_value(mmb_pkg::CFG_BAR));
            end
            if ($urandom_range(0, 3) == 0) begin
                set_reg(mmb_pkg::CFG_ENABLED, {8'($urandom), 1'b0});
                cfg_idle();
                repeat ($urandom_range(2, 4)) begin
                    restart_ms = clock_ms - $urandom_range(0, 400);
                    queue_tick($urandom, restart_ms);
                end
                clock_ms = restart_ms;
                drain();
            end
            set_reg(mmb_pkg::CFG_ENABLED, {8'($urandom), 1'b1});
            cfg_idle();
            queue_stream(TICKS_PER_PHASE);
        end

        drain();
        if (mismatches == 0 && owed_midi.size() == 0) begin
            $display("tb_midi_metronome_beat_generator: clean");
        end else begin
            $display("tb_midi_metronome_beat_generator: errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
src/mmb_pkg.sv
src/mmb_if.sv
src/midi_metronome_beat_generator.sv
verif/tb_midi_metronome_beat_generator.sv
